// ===== sv/utf8v_pkg.sv =====
package utf8v_pkg;

    // Default width of the length limit
    localparam int DEFAULT_LENGTH_BITS = 16;
    localparam int DEFAULT_MAX_LENGTH  = 1023;

    localparam int CODE_BITS = 21;

    // Byte classes
    localparam logic [7:0] ASCII_TOP   = 8'h7F;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Code point limits
    localparam logic [CODE_BITS-1:0] CODE_MAX     = 21'h10FFFF;
    localparam logic [CODE_BITS-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CODE_BITS-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CODE_BITS-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CODE_BITS-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CODE_BITS-1:0] MIN_FOUR     = 21'h010000;

    // Sequence length class: names give total bytes, values the continuation bytes expected
    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_class_t;

    // Smallest legal code point for a sequence length (overlong check)
    function automatic logic [CODE_BITS-1:0] min_code(input seq_class_t cls);
        logic [CODE_BITS-1:0] lim;
        case (cls)
            SEQ_TWO:   lim = MIN_TWO;
            SEQ_THREE: lim = MIN_THREE;
            SEQ_FOUR:  lim = MIN_FOUR;
            default:   lim = MIN_FOUR;
        endcase
        return lim;
    endfunction

endpackage

// ===== sv/utf8_text_validator.sv =====
// Channel   Signals                                  Direction  Word
// input     in_valid, in_ready, text_byte            in         one string byte
// result    out_valid, out_ready, text_valid,        out        one verdict
//           byte_count
// config    cfg_valid, cfg_ready, max_length         in         length limit
//
// One byte per cycle sustained, except while a zero byte waits on an unread
// verdict. A byte is held in an input register, then decoded against the
// sequence state; a zero byte's verdict goes to the result register as it leaves.
// rst_n is asynchronous and clears all string state; the limit resets to 1023.
// A waiting verdict stalls only the terminator behind it; other bytes go on.
module utf8_text_validator #(
    parameter int LENGTH_BITS = utf8v_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             text_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   text_valid,
    output logic [LENGTH_BITS:0]   byte_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LENGTH_BITS-1:0] max_length
);
    import utf8v_pkg::*;

    localparam int CNT_BITS = LENGTH_BITS + 1;

    // Registers
    logic [LENGTH_BITS-1:0] limit_reg;
    logic [7:0]             byte_reg;
    logic                   byte_valid_reg;
    logic [1:0]             pend_reg, pend_next;
    logic [CODE_BITS-1:0]   acc_reg, acc_next;
    seq_class_t             class_reg, class_next;
    logic                   err_reg, err_next;
    logic [CNT_BITS-1:0]    len_reg, len_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   verdict_reg, verdict_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    logic                   is_term;
    logic                   advance;
    logic                   in_take;
    logic [CNT_BITS-1:0]    limit_ext;

    // Lead-byte decode
    logic                   start_err;
    seq_class_t             start_class;
    logic [1:0]             start_pend;
    logic [CODE_BITS-1:0]   start_acc;
    logic                   is_cont;
    logic [CODE_BITS-1:0]   shift_acc;
    logic                   code_bad;

    assign limit_ext = {1'b0, limit_reg};
    assign is_term   = (byte_reg == CHAR_NUL);
    assign advance   = byte_valid_reg && (!is_term || !out_valid_reg || out_ready);
    assign in_ready  = !byte_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign text_valid = verdict_reg;
    assign byte_count = count_reg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LENGTH_BITS'(DEFAULT_MAX_LENGTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= max_length;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= text_byte;
        end
    end

    // Start of a new character
    always_comb
    begin
        start_err   = 1'b0;
        start_class = SEQ_NONE;
        start_pend  = 2'd0;
        start_acc   = '0;
        if (byte_reg <= ASCII_TOP)
        begin
            start_err = ((byte_reg < CHAR_SPACE) && (byte_reg != CHAR_LF)
                         && (byte_reg != CHAR_TAB)) || (byte_reg == CHAR_DEL);
        end
        else if (byte_reg inside {[LEAD2_LO:LEAD2_HI]})
        begin
            start_class = SEQ_TWO;
            start_pend  = 2'd1;
            start_acc   = CODE_BITS'(byte_reg[4:0]);
        end
        else if (byte_reg inside {[LEAD3_LO:LEAD3_HI]})
        begin
            start_class = SEQ_THREE;
            start_pend  = 2'd2;
            start_acc   = CODE_BITS'(byte_reg[3:0]);
        end
        else if (byte_reg inside {[LEAD4_LO:LEAD4_HI]})
        begin
            start_class = SEQ_FOUR;
            start_pend  = 2'd3;
            start_acc   = CODE_BITS'(byte_reg[2:0]);
        end
        else
        begin
            start_err = 1'b1;
        end
    end

    // Continuation and end-of-sequence checks
    assign is_cont   = (byte_reg[7:6] == CONT_TAG);
    assign shift_acc = {acc_reg[CODE_BITS-7:0], byte_reg[5:0]};
    assign code_bad  = (shift_acc < min_code(class_reg)) || (shift_acc > CODE_MAX)
                       || ((shift_acc >= SURR_LO) && (shift_acc <= SURR_HI));

    // Next string state and result
    always_comb
    begin
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        class_next     = class_reg;
        err_next       = err_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        count_next     = count_reg;
        if (advance)
        begin
            if (is_term)
            begin
                out_valid_next = 1'b1;
                verdict_next   = !err_reg && (pend_reg == 2'd0) && (len_reg != '0)
                                 && (len_reg <= limit_ext);
                count_next     = len_reg;
                pend_next      = 2'd0;
                acc_next       = '0;
                class_next     = SEQ_NONE;
                err_next       = 1'b0;
                len_next       = '0;
            end
            else
            begin
                if (len_reg <= limit_ext)
                begin
                    len_next = len_reg + CNT_BITS'(1);
                end
                if ((pend_reg != 2'd0) && is_cont)
                begin
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        err_next   = err_reg || code_bad;
                        acc_next   = '0;
                        class_next = SEQ_NONE;
                    end
                    else
                    begin
                        acc_next = shift_acc;
                    end
                end
                else
                begin
                    // broken sequence or fresh character
                    err_next   = err_reg || start_err || (pend_reg != 2'd0);
                    pend_next  = start_pend;
                    acc_next   = start_acc;
                    class_next = start_class;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            acc_reg       <= '0;
            class_reg     <= SEQ_NONE;
            err_reg       <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            class_reg     <= class_next;
            err_reg       <= err_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        count_reg   <= count_next;
    end

    // Checks
    a_class_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) == (class_reg == SEQ_NONE))
        else $error("pending count and sequence class disagree");

    a_pend_le_class: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'(class_reg))
        else $error("more continuations pending than the sequence holds");

    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= limit_ext + CNT_BITS'(1))
        else $error("length counter past saturation");

    a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_term |=> (len_reg == '0) && !err_reg && (pend_reg == 2'd0)
                               && out_valid_reg)
        else $error("string state not cleared after verdict");

    a_good_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg |-> (count_reg != '0) && (count_reg <= limit_ext))
        else $error("accepted string with bad length");

endmodule
